>>> sv/cpi_pkg.sv
package cpi_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_INTEG_UPPER = 3'd2,
		REG_INTEG_LOWER = 3'd3,
		REG_DRIVE_UPPER = 3'd4,
		REG_DRIVE_LOWER = 3'd5,
		REG_LOOPBACK    = 3'd6
	} cpi_reg_t;

	typedef struct packed {
		logic        [15:0] prop_gain;
		logic        [15:0] integ_gain;
		logic signed [15:0] integ_upper;
		logic signed [15:0] integ_lower;
		logic signed [15:0] drive_upper;
		logic signed [15:0] drive_lower;
		logic               loopback;
	} cpi_cfg_t;

	localparam logic        [15:0] PROP_GAIN_RST   = 16'd200;
	localparam logic        [15:0] INTEG_GAIN_RST  = 16'd550;
	localparam logic signed [15:0] INTEG_UPPER_RST = 16'sd10000;
	localparam logic signed [15:0] INTEG_LOWER_RST = -16'sd10000;
	localparam logic signed [15:0] DRIVE_UPPER_RST = 16'sd10000;
	localparam logic signed [15:0] DRIVE_LOWER_RST = -16'sd10000;
	localparam logic               LOOPBACK_RST    = 1'b1;

	// upper test wins when the limits are crossed
	function automatic logic signed [15:0] clamp_hi_first(
		input logic signed [33:0] v,
		input logic signed [15:0] hi,
		input logic signed [15:0] lo
	);
		logic signed [15:0] r;
		if (v > 34'(hi)) begin
			r = hi;
		end else if (v < 34'(lo)) begin
			r = lo;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// x / 2 rounded toward zero
	function automatic logic signed [15:0] half_trunc(input logic signed [15:0] x);
		logic signed [16:0] t;
		t = 17'(x) + 17'($signed({16'd0, x[15]}));
		t = t >>> 1;
		return t[15:0];
	endfunction

endpackage

>>> sv/cpi_ifs.sv
interface cpi_tick_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] reference_current;
	logic signed [15:0] measured_current;

	modport source(output valid, reference_current, measured_current, input ready);
	modport sink(input valid, reference_current, measured_current, output ready);
endinterface

interface cpi_drive_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive_output;

	modport source(output valid, drive_output, input ready);
	modport sink(input valid, drive_output, output ready);
endinterface

interface cpi_cfg_if import cpi_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/current_pi_controller_top.sv
// A word accepted into the input stage has its result loaded into the output register.
// Throughput: one word per cycle while drive.ready does not stall the output; the error,
// both gain products, the integrator clamp and the drive clamp all settle between the
// input stage and the output register. Reset (arst_n low): integrator and last drive
// cleared, registers at their defaults, input stage and output register empty.
module current_pi_controller_top
	import cpi_pkg::*;
#(
	parameter int FRAC_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	cpi_tick_if.sink    tick,
	cpi_drive_if.source drive,
	cpi_cfg_if.sink     cfg
);

	cpi_cfg_t regs;

	cpi_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	logic               valid_s1;
	logic signed [15:0] ref_s1;
	logic signed [15:0] meas_s1;
	logic               out_valid_q;
	logic signed [15:0] drive_q;
	logic signed [15:0] integrator_q;
	logic signed [15:0] last_drive_q;

	logic               advance;
	logic signed [15:0] meas;
	logic signed [16:0] err;
	logic signed [33:0] prod_p;
	logic signed [33:0] prod_i;
	logic signed [33:0] p_shr;
	logic signed [33:0] i_sum;
	logic signed [15:0] i_new;
	logic signed [33:0] pi_sum;
	logic signed [33:0] pi_adj;
	logic               halve;
	logic signed [15:0] drive_new;

	assign advance    = valid_s1 && (!out_valid_q || drive.ready);
	assign tick.ready = !valid_s1 || advance;

	assign drive.valid        = out_valid_q;
	assign drive.drive_output = drive_q;

	always_comb begin
		meas   = regs.loopback ? last_drive_q : meas_s1;
		err    = 17'(ref_s1) - 17'(meas);
		prod_p = 34'(err) * 34'($signed({1'b0, regs.prop_gain}));
		prod_i = 34'(err) * 34'($signed({1'b0, regs.integ_gain}));
		p_shr  = prod_p >>> FRAC_BITS;
		i_sum  = (prod_i >>> FRAC_BITS) + 34'(integrator_q);
		i_new  = clamp_hi_first(i_sum, regs.integ_upper, regs.integ_lower);
		pi_sum = p_shr + 34'(i_new);
		halve  = (err > 17'(half_trunc(regs.integ_upper)))
			|| (err < 17'(half_trunc(regs.integ_lower)));
		pi_adj    = halve ? (pi_sum >>> 1) : pi_sum;
		drive_new = clamp_hi_first(pi_adj, regs.drive_upper, regs.drive_lower);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			integrator_q <= '0;
			last_drive_q <= '0;
		end else begin
			if (tick.valid && tick.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q  <= 1'b1;
				integrator_q <= i_new;
				last_drive_q <= drive_new;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			ref_s1  <= tick.reference_current;
			meas_s1 <= tick.measured_current;
		end
		if (advance) begin
			drive_q <= drive_new;
		end
	end

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> drive.valid)
		else $error("output register not loaded after advance");

	a_held_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |-> (last_drive_q == drive_q))
		else $error("held word differs from last drive state");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> tick.ready)
		else $error("empty input stage not ready");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> (valid_s1 && drive.valid && !drive.ready))
		else $error("input stalled without downstream backpressure");

endmodule

>>> sv/cpi_cfg_regs.sv
module cpi_cfg_regs
	import cpi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cpi_cfg_if.sink   cfg,
	output cpi_cfg_t  regs
);

	cpi_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.prop_gain   <= PROP_GAIN_RST;
			regs_q.integ_gain  <= INTEG_GAIN_RST;
			regs_q.integ_upper <= INTEG_UPPER_RST;
			regs_q.integ_lower <= INTEG_LOWER_RST;
			regs_q.drive_upper <= DRIVE_UPPER_RST;
			regs_q.drive_lower <= DRIVE_LOWER_RST;
			regs_q.loopback    <= LOOPBACK_RST;
		end else if (cfg.valid) begin
			unique case (cpi_reg_t'(cfg.index))
				REG_PROP_GAIN:   regs_q.prop_gain   <= cfg.data;
				REG_INTEG_GAIN:  regs_q.integ_gain  <= cfg.data;
				REG_INTEG_UPPER: regs_q.integ_upper <= $signed(cfg.data);
				REG_INTEG_LOWER: regs_q.integ_lower <= $signed(cfg.data);
				REG_DRIVE_UPPER: regs_q.drive_upper <= $signed(cfg.data);
				REG_DRIVE_LOWER: regs_q.drive_lower <= $signed(cfg.data);
				REG_LOOPBACK:    regs_q.loopback    <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import cpi_pkg::*;

	localparam int FRAC_BITS   = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_TICKS = 125;

	class pi_drive_scoreboard;
		bit [15:0] prop_gain;
		bit [15:0] integ_gain;
		shortint   integ_upper;
		shortint   integ_lower;
		shortint   drive_upper;
		shortint   drive_lower;
		bit        loopback;
		shortint   integrator;
		shortint   last_drive;
		shortint   expected_drive[$];
		int        mismatches;
		int        checked;
		int        halved;

		function new();
			prop_gain   = PROP_GAIN_RST;
			integ_gain  = INTEG_GAIN_RST;
			integ_upper = INTEG_UPPER_RST;
			integ_lower = INTEG_LOWER_RST;
			drive_upper = DRIVE_UPPER_RST;
			drive_lower = DRIVE_LOWER_RST;
			loopback    = LOOPBACK_RST;
			integrator  = 0;
			last_drive  = 0;
			mismatches  = 0;
			checked     = 0;
			halved      = 0;
		endfunction

		function void apply_write(cpi_reg_t idx, logic [15:0] d);
			case (idx)
				REG_PROP_GAIN: begin
					prop_gain = d;
				end
				REG_INTEG_GAIN: begin
					integ_gain = d;
				end
				REG_INTEG_UPPER: begin
					integ_upper = $signed(d);
				end
				REG_INTEG_LOWER: begin
					integ_lower = $signed(d);
				end
				REG_DRIVE_UPPER: begin
					drive_upper = $signed(d);
				end
				REG_DRIVE_LOWER: begin
					drive_lower = $signed(d);
				end
				REG_LOOPBACK: begin
					loopback = d[0];
				end
				default: begin
				end
			endcase
		endfunction

		// upper bound checked first, so it wins where a value exceeds both crossed limits
		function longint limit(longint v, shortint hi, shortint lo);
			if (v > hi) begin
				return hi;
			end
			if (v < lo) begin
				return lo;
			end
			return v;
		endfunction

		function void note_tick(shortint r, shortint m);
			longint err;
			longint p;
			longint i;
			longint s;
			err = longint'(r) - (loopback ? longint'(last_drive) : longint'(m));
			p = (err * longint'(prop_gain)) >>> FRAC_BITS;
			i = ((err * longint'(integ_gain)) >>> FRAC_BITS) + integrator;
			i = limit(i, integ_upper, integ_lower);
			integrator = shortint'(i);
			s = p + i;
			if (err > integ_upper / 2 || err < integ_lower / 2) begin
				s = s >>> 1;
				halved++;
			end
			last_drive = shortint'(limit(s, drive_upper, drive_lower));
			expected_drive.push_back(last_drive);
		endfunction

		function void check_drive(shortint got);
			shortint want;
			if (expected_drive.size() == 0) begin
				$display("%0t: drive_output expected none, got %0d", $time, got);
				mismatches++;
				return;
			end
			want = expected_drive.pop_front();
			checked++;
			if (want != got) begin
				$display("%0t: drive_output expected %0d, got %0d", $time, want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   settings = 0;
	bit   quiet = 1'b0;

	pi_drive_scoreboard sb;

	cpi_tick_if  tick_if();
	cpi_drive_if drive_if();
	cpi_cfg_if   cfg_if();

	current_pi_controller_top #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_if),
		.drive (drive_if),
		.cfg   (cfg_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end else if (arst_n) begin
			if (drive_if.valid && drive_if.ready) begin
				sb.check_drive(drive_if.drive_output);
			end
			if (tick_if.valid && tick_if.ready) begin
				sb.note_tick(tick_if.reference_current, tick_if.measured_current);
			end
			if (cfg_if.valid && cfg_if.ready) begin
				sb.apply_write(cpi_reg_t'(cfg_if.index), cfg_if.data);
			end
		end
	end

	always @(negedge clk) begin
		drive_if.ready <= quiet || $urandom_range(99) >= 30;
	end

	task automatic send_tick(logic signed [15:0] r, logic signed [15:0] m);
		if (!quiet && $urandom_range(99) < 30) begin
			tick_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		tick_if.valid             <= 1'b1;
		tick_if.reference_current <= r;
		tick_if.measured_current  <= m;
		@(posedge clk);
		while (!tick_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cpi_reg_t idx, logic [15:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= d;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		tick_if.valid <= 1'b0;
		while (sb.expected_drive.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic load_settings(logic [15:0] kp, logic [15:0] ki, logic [15:0] iu,
		logic [15:0] il, logic [15:0] du, logic [15:0] dl, logic lb);
		drain();
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_INTEG_UPPER, iu);
		write_reg(REG_INTEG_LOWER, il);
		write_reg(REG_DRIVE_UPPER, du);
		write_reg(REG_DRIVE_LOWER, dl);
		write_reg(REG_LOOPBACK, {15'd0, lb});
		cfg_if.valid <= 1'b0;
		settings++;
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 2048));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_current();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2, 3: return 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic load_random_settings();
		logic signed [15:0] iu;
		logic signed [15:0] il;
		logic signed [15:0] du;
		logic signed [15:0] dl;
		iu = pick_current();
		il = pick_current();
		du = pick_current();
		dl = pick_current();
		// mostly ordered limits, now and then crossed ones
		if ($urandom_range(4) != 0) begin
			if (iu < il) begin
				{iu, il} = {il, iu};
			end
			if (du < dl) begin
				{du, dl} = {dl, du};
			end
		end
		load_settings(pick_gain(), pick_gain(), iu, il, du, dl, 1'($urandom_range(1)));
	endtask

	initial begin
		logic signed [15:0] target;
		logic signed [15:0] meas;
		int                 hold;
		sb = new();
		arst_n                    = 1'b0;
		tick_if.valid             = 1'b0;
		tick_if.reference_current = '0;
		tick_if.measured_current  = '0;
		drive_if.ready            = 1'b0;
		cfg_if.valid              = 1'b0;
		cfg_if.index              = REG_PROP_GAIN;
		cfg_if.data               = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults, loopback on
		send_tick(16'sd1000, 16'sd0);
		send_tick(16'h7FFF, 16'sd0);
		send_tick(16'h8000, 16'sd0);
		send_tick(-16'sd1, 16'sd0);
		send_tick(16'sd0, 16'sd0);

		// full-scale gains and limits: widest products, floor shifts of negatives
		load_settings(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
		send_tick(16'h7FFF, 16'h8000);
		send_tick(16'h8000, 16'h7FFF);
		send_tick(-16'sd1, 16'sd0);
		send_tick(16'sd1, 16'sd0);
		send_tick(16'h8000, 16'h8000);
		send_tick(16'h7FFF, 16'h7FFF);

		// crossed limits on both clamps
		load_settings(16'd1024, 16'd300, -16'sd100, 16'sd100, -16'sd50, 16'sd50, 1'b0);
		send_tick(16'sd500, 16'sd0);
		send_tick(-16'sd500, 16'sd0);
		send_tick(16'sd0, 16'sd0);
		send_tick(16'sd20, 16'sd0);

		// zero gains and zero limits
		load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
		send_tick(16'sd5, -16'sd5);
		send_tick(-16'sd7, 16'sd3);
		send_tick(16'sd0, 16'sd0);

		// reference steps held for a while, measurement near it or anywhere
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			load_random_settings();
			quiet = (ph == 2);
			hold = 0;
			repeat (PHASE_TICKS) begin
				if (hold == 0) begin
					target = pick_current();
					hold = $urandom_range(1, 20);
				end
				hold--;
				meas = $urandom_range(1) ? target + 16'($urandom_range(0, 63)) - 16'd32
					: pick_current();
				send_tick(target, meas);
			end
		end
		quiet = 1'b0;
		drain();

		$display("Checked %0d drive words over %0d register settings, %0d of them halved",
			sb.checked, settings, sb.halved);
		if (sb.mismatches == 0 && sb.expected_drive.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
sv/cpi_pkg.sv
sv/cpi_ifs.sv
sv/cpi_cfg_regs.sv
sv/current_pi_controller_top.sv
test/tb.sv
